// ----- src/rcc_pkg.sv -----
// Shared types, constants and register codes for the RC channel conditioner.
package rcc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned MASK_BITS   = 16;
  localparam int unsigned GAIN_BITS   = 9;
  localparam int unsigned CHAN_BITS   = 5;
  localparam int unsigned SW_BITS     = 2;
  localparam int unsigned NORM_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  // Filter arithmetic
  localparam int unsigned PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 9'd256;

  // Reset value of the kept pulse width (failsafe)
  localparam logic [SAMPLE_BITS-1:0] FAILSAFE_WIDTH = 12'd1500;

  // Switch position thresholds
  localparam logic [SAMPLE_BITS-1:0] SWITCH_LOW_EDGE  = 12'd1250;
  localparam logic [SAMPLE_BITS-1:0] SWITCH_HIGH_EDGE = 12'd1750;

  // Normalisation: Q2.14 quotient, 15 magnitude bits once saturation is ruled out
  localparam int unsigned QUOT_BITS = 15;
  localparam int unsigned DIV_STEPS = QUOT_BITS;
  localparam int unsigned CNT_BITS  = 4;
  localparam logic signed [NORM_BITS-1:0] NORM_MAX = 16'sh7FFF;
  localparam logic signed [NORM_BITS-1:0] NORM_MIN = 16'sh8000;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] RST_ZERO_POINT = 12'd1500;
  localparam logic [SAMPLE_BITS-1:0] RST_FULL_SCALE = 12'd2000;
  localparam logic [GAIN_BITS-1:0]   RST_GAIN       = 9'd128;
  localparam logic [CHAN_BITS-1:0]   RST_CHANNEL    = 5'd1;
  localparam logic [SAMPLE_BITS-1:0] RST_LOW_LIMIT  = 12'd800;
  localparam logic [SAMPLE_BITS-1:0] RST_HIGH_LIMIT = 12'd2200;

  // Switch position codes
  localparam logic [SW_BITS-1:0] SW_LOW  = 2'd0;
  localparam logic [SW_BITS-1:0] SW_MID  = 2'd1;
  localparam logic [SW_BITS-1:0] SW_HIGH = 2'd2;

  // Register indices
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ZERO_POINT  = 3'd0,
    REG_FULL_SCALE  = 3'd1,
    REG_FILTER_EN   = 3'd2,
    REG_FILTER_GAIN = 3'd3,
    REG_CHANNEL_IDX = 3'd4,
    REG_LOW_LIMIT   = 3'd5,
    REG_HIGH_LIMIT  = 3'd6
  } reg_index_e;

  // Input item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pulse_width;
    logic [MASK_BITS-1:0]   failure_mask_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]      channel_value;
    logic [MASK_BITS-1:0]        failure_mask_out;
    logic [SW_BITS-1:0]          switch_position;
    logic signed [NORM_BITS-1:0] normalized_value;
    logic                        normalize_error;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] zero_point;
    logic [SAMPLE_BITS-1:0] full_scale_point;
    logic                   filter_enable;
    logic [GAIN_BITS-1:0]   filter_gain;
    logic [CHAN_BITS-1:0]   channel_index;
    logic [SAMPLE_BITS-1:0] low_limit;
    logic [SAMPLE_BITS-1:0] high_limit;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic filt_mul;
    logic filt_sum;
    logic check;
    logic div_step;
    logic write_out;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_div;
  } dp_status_t;

endpackage

// ----- src/rc_channel_conditioner.sv -----
// Top level of the RC channel conditioner: config registers, controller, datapath.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid_i/in_stall_o     in_data_i  (rcc_pkg::in_item_t)
//  out      source     out_valid_o/out_stall_i   out_data_o (rcc_pkg::out_item_t)
//  cfg      sink       cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item at a time: the next input transfer waits until the result is written.
// The filter adds its multiply and sum states; the 15-step restoring divider
// dominates. A saturated or invalid normalisation skips the divider.
// The result register holds a finished result while the next item is taken.
// Reset restores register defaults and a kept value of 1500; no clearing pass.
module rc_channel_conditioner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rcc_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rcc_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  rcc_pkg::cfg_t       cfg;
  rcc_pkg::ctl_cmd_t   cmd;
  rcc_pkg::dp_status_t status;

  // Configuration registers
  rcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Controller
  rcc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filter_enable_i (cfg.filter_enable),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Datapath
  rcc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ----- src/rcc_cfg_regs.sv -----
// Configuration register file with write decode and reset values.
module rcc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output rcc_pkg::cfg_t                     cfg_o
);

  rcc_pkg::cfg_t cfg_q;
  rcc_pkg::cfg_t cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Write decode; unused indices are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcc_pkg::REG_ZERO_POINT:  cfg_d.zero_point       = cfg_data_i[rcc_pkg::SAMPLE_BITS-1:0];
        rcc_pkg::REG_FULL_SCALE:  cfg_d.full_scale_point = cfg_data_i[rcc_pkg::SAMPLE_BITS-1:0];
        rcc_pkg::REG_FILTER_EN:   cfg_d.filter_enable    = cfg_data_i[0];
        rcc_pkg::REG_FILTER_GAIN: cfg_d.filter_gain      = cfg_data_i[rcc_pkg::GAIN_BITS-1:0];
        rcc_pkg::REG_CHANNEL_IDX: cfg_d.channel_index    = cfg_data_i[rcc_pkg::CHAN_BITS-1:0];
        rcc_pkg::REG_LOW_LIMIT:   cfg_d.low_limit        = cfg_data_i[rcc_pkg::SAMPLE_BITS-1:0];
        rcc_pkg::REG_HIGH_LIMIT:  cfg_d.high_limit       = cfg_data_i[rcc_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_point       <= rcc_pkg::RST_ZERO_POINT;
      cfg_q.full_scale_point <= rcc_pkg::RST_FULL_SCALE;
      cfg_q.filter_enable    <= 1'b0;
      cfg_q.filter_gain      <= rcc_pkg::RST_GAIN;
      cfg_q.channel_index    <= rcc_pkg::RST_CHANNEL;
      cfg_q.low_limit        <= rcc_pkg::RST_LOW_LIMIT;
      cfg_q.high_limit       <= rcc_pkg::RST_HIGH_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/rcc_ctrl.sv -----
// Sequencing state machine: input transfer, filter, range check, divide, result.
module rcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                filter_enable_i,
  input  rcc_pkg::dp_status_t status_i,
  output rcc_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT_MUL,
    S_FILT_SUM,
    S_CHECK,
    S_DIV,
    S_WRITE
  } state_e;

  state_e                          state_q;
  logic [rcc_pkg::CNT_BITS-1:0]    count_q;
  logic                            out_valid_q;
  logic                            slot_free;
  logic                            div_last;

  // Output register can take a new result when empty or being emptied
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign div_last   = (count_q == rcc_pkg::CNT_BITS'(rcc_pkg::DIV_STEPS - 1));
  assign in_stall_o = (state_q != S_IDLE);

  // Command decode
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.load      = in_valid_i;
      S_FILT_MUL: cmd_o.filt_mul  = 1'b1;
      S_FILT_SUM: cmd_o.filt_sum  = 1'b1;
      S_CHECK:    cmd_o.check     = 1'b1;
      S_DIV:      cmd_o.div_step  = 1'b1;
      S_WRITE:    cmd_o.write_out = slot_free;
      default:    cmd_o = '0;
    endcase
  end

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.write_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= filter_enable_i ? S_FILT_MUL : S_CHECK;
          end
        end
        S_FILT_MUL: state_q <= S_FILT_SUM;
        S_FILT_SUM: state_q <= S_CHECK;
        S_CHECK: begin
          count_q <= '0;
          state_q <= status_i.skip_div ? S_WRITE : S_DIV;
        end
        S_DIV: begin
          count_q <= count_q + 1'b1;
          if (div_last) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/rcc_datapath.sv -----
// Datapath: kept value, low-pass filter, range and switch checks,
// restoring divider for normalisation, result register.
module rcc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcc_pkg::cfg_t       cfg_i,
  input  rcc_pkg::in_item_t   in_data_i,
  input  rcc_pkg::ctl_cmd_t   cmd_i,
  output rcc_pkg::dp_status_t status_o,
  output rcc_pkg::out_item_t  out_data_o
);

  localparam int unsigned SB = rcc_pkg::SAMPLE_BITS;
  localparam int unsigned MB = rcc_pkg::MASK_BITS;
  localparam int unsigned GB = rcc_pkg::GAIN_BITS;
  localparam int unsigned PB = rcc_pkg::PROD_BITS;
  localparam int unsigned QB = rcc_pkg::QUOT_BITS;

  logic [SB-1:0]  kept_q, kept_d;
  logic [SB-1:0]  sample_q;
  logic [MB-1:0]  mask_q;
  logic [PB-1:0]  prod_q;
  logic [SB-1:0]  den_q;
  logic [SB:0]    rem_q;
  logic [QB-1:0]  quot_q;
  logic           neg_q, sat_q, err_q;
  logic [rcc_pkg::SW_BITS-1:0] sw_q;
  rcc_pkg::out_item_t out_q;

  logic [GB-1:0]  gain;
  logic [PB:0]    filt_sum;
  logic [SB:0]    diff, den;
  logic [SB-1:0]  abs_diff;
  logic           den_pos, sat;
  logic           fail;
  logic [MB-1:0]  chan_bit;
  logic [rcc_pkg::SW_BITS-1:0] sw;
  logic [SB:0]    trial;
  logic           qbit;
  logic [SB-1:0]  rem_next;
  logic signed [rcc_pkg::NORM_BITS-1:0] norm;

  // Gain above one is treated as one
  assign gain = (cfg_i.filter_gain > rcc_pkg::GAIN_ONE) ? rcc_pkg::GAIN_ONE : cfg_i.filter_gain;

  // Second filter term added to the registered first term
  assign filt_sum = {1'b0, prod_q} + (PB + 1)'(gain * sample_q);

  // Kept value update: raw on load with the filter off, or filtered over the multiply and sum steps
  always_comb begin
    kept_d = kept_q;
    if (cmd_i.load && !cfg_i.filter_enable) begin
      kept_d = in_data_i.pulse_width;
    end else if (cmd_i.filt_sum) begin
      kept_d = filt_sum[SB+7:8];
    end
  end

  // Normalisation set-up: numerator magnitude, sign, divisor and saturation
  assign diff     = {1'b0, kept_q} - {1'b0, cfg_i.zero_point};
  assign abs_diff = diff[SB] ? SB'(-diff) : diff[SB-1:0];
  assign den      = {1'b0, cfg_i.full_scale_point} - {1'b0, cfg_i.zero_point};
  assign den_pos  = !den[SB] && (den != '0);
  // |diff| >= 2*den means the Q2.14 quotient reaches 2.0 and saturates
  assign sat      = ({1'b0, abs_diff} >= {den[SB-1:0], 1'b0});
  assign status_o.skip_div = !den_pos || sat;

  // Range check and failure bit decode
  assign fail = (kept_q > cfg_i.high_limit) || (kept_q < cfg_i.low_limit);
  always_comb begin
    for (int j = 0; j < MB; j++) begin
      chan_bit[j] = fail && (cfg_i.channel_index == rcc_pkg::CHAN_BITS'(j + 1));
    end
  end

  // Switch position
  always_comb begin
    priority if (kept_q < rcc_pkg::SWITCH_LOW_EDGE) begin
      sw = rcc_pkg::SW_LOW;
    end else if (kept_q < rcc_pkg::SWITCH_HIGH_EDGE) begin
      sw = rcc_pkg::SW_MID;
    end else begin
      sw = rcc_pkg::SW_HIGH;
    end
  end

  // One restoring divide step; remainder is kept pre-shifted
  assign qbit     = (rem_q >= {1'b0, den_q});
  assign trial    = rem_q - {1'b0, den_q};
  assign rem_next = qbit ? trial[SB-1:0] : rem_q[SB-1:0];

  // Final normalised value
  always_comb begin
    priority if (err_q) begin
      norm = '0;
    end else if (sat_q) begin
      norm = neg_q ? rcc_pkg::NORM_MIN : rcc_pkg::NORM_MAX;
    end else if (neg_q) begin
      norm = -$signed({1'b0, quot_q});
    end else begin
      norm = $signed({1'b0, quot_q});
    end
  end

  // Kept value state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= rcc_pkg::FAILSAFE_WIDTH;
    end else begin
      kept_q <= kept_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_data_i.pulse_width;
      mask_q   <= in_data_i.failure_mask_in;
    end
    if (cmd_i.filt_mul) begin
      prod_q <= PB'((rcc_pkg::GAIN_ONE - gain) * kept_q);
    end
    if (cmd_i.check) begin
      mask_q <= mask_q | chan_bit;
      sw_q   <= sw;
      neg_q  <= diff[SB];
      sat_q  <= sat;
      err_q  <= !den_pos;
      den_q  <= den[SB-1:0];
      rem_q  <= {1'b0, abs_diff};
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_next, 1'b0};
      quot_q <= {quot_q[QB-2:0], qbit};
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      out_q.channel_value    <= kept_q;
      out_q.failure_mask_out <= mask_q;
      out_q.switch_position  <= sw_q;
      out_q.normalized_value <= norm;
      out_q.normalize_error  <= err_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- src/rcc_checker.sv -----
// Port-level checks for the RC channel conditioner, bound to the top level.
module rcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rcc_pkg::out_item_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // After an input transfer the block is busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a transfer");

  // An invalid divisor gives a zero normalised value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.normalize_error |-> out_data_o.normalized_value == '0)
    else $error("normalisation error with non-zero value");

endmodule

bind rc_channel_conditioner rcc_checker u_rcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/rcc_result_checker.sv -----
// Result checker for the RC channel conditioner: predicts each transfer and compares.
module rcc_result_checker
  import rcc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  in_item_t                 in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  out_item_t                out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              outstanding_o
);

  localparam int Q14_ONE       = 1 << 14;
  localparam int MAX_REPORTS   = 10;
  localparam int MASK_IDX_BITS = $clog2(MASK_BITS);

  cfg_t                   shadow_regs;
  logic [SAMPLE_BITS-1:0] kept_width;
  out_item_t              conditioned_q[$];
  out_item_t              want;
  int unsigned            results_seen;

  // Condition one pulse: smooth or pass, range check, switch decode, Q2.14 scaling
  function automatic out_item_t condition_pulse(input cfg_t c,
                                                input logic [SAMPLE_BITS-1:0] prev,
                                                input in_item_t item);
    out_item_t r;
    int        g;
    int        v;
    int        den;
    int        num;
    int        q;
    r = '0;
    if (c.filter_enable) begin
      // gains beyond unity clamp to unity
      g = (c.filter_gain > GAIN_ONE) ? int'(GAIN_ONE) : int'(c.filter_gain);
      v = ((int'(GAIN_ONE) - g) * int'(prev) + g * int'(item.pulse_width)) >> 8;
    end else begin
      v = int'(item.pulse_width);
    end
    r.channel_value = v[SAMPLE_BITS-1:0];

    // out of range (or crossed limits) marks this channel's bit, if it has one
    r.failure_mask_out = item.failure_mask_in;
    if ((v > int'(c.high_limit) || v < int'(c.low_limit)) &&
        c.channel_index >= 1 && c.channel_index <= MASK_BITS)
      r.failure_mask_out[MASK_IDX_BITS'(c.channel_index - 5'd1)] = 1'b1;

    // exactly 1250 is already mid position
    if (v < int'(SWITCH_LOW_EDGE))       r.switch_position = SW_LOW;
    else if (v < int'(SWITCH_HIGH_EDGE)) r.switch_position = SW_MID;
    else                                 r.switch_position = SW_HIGH;

    // non-positive span flags an error and reads zero
    den = int'(c.full_scale_point) - int'(c.zero_point);
    if (den <= 0) begin
      r.normalized_value = '0;
      r.normalize_error  = 1'b1;
    end else begin
      num = (v - int'(c.zero_point)) * Q14_ONE;
      q   = num / den;
      if (q > int'(NORM_MAX)) q = int'(NORM_MAX);
      if (q < int'(NORM_MIN)) q = int'(NORM_MIN);
      r.normalized_value = q[NORM_BITS-1:0];
      r.normalize_error  = 1'b0;
    end
    return r;
  endfunction

  // Track register writes, score results, then queue predictions for new inputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_regs.zero_point       = RST_ZERO_POINT;
      shadow_regs.full_scale_point = RST_FULL_SCALE;
      shadow_regs.filter_enable    = 1'b0;
      shadow_regs.filter_gain      = RST_GAIN;
      shadow_regs.channel_index    = RST_CHANNEL;
      shadow_regs.low_limit        = RST_LOW_LIMIT;
      shadow_regs.high_limit       = RST_HIGH_LIMIT;
      kept_width    = FAILSAFE_WIDTH;
      conditioned_q.delete();
      results_seen  = 0;
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_index_e'(cfg_index_i))
          REG_ZERO_POINT:  shadow_regs.zero_point       = cfg_data_i[SAMPLE_BITS-1:0];
          REG_FULL_SCALE:  shadow_regs.full_scale_point = cfg_data_i[SAMPLE_BITS-1:0];
          REG_FILTER_EN:   shadow_regs.filter_enable    = cfg_data_i[0];
          REG_FILTER_GAIN: shadow_regs.filter_gain      = cfg_data_i[GAIN_BITS-1:0];
          REG_CHANNEL_IDX: shadow_regs.channel_index    = cfg_data_i[CHAN_BITS-1:0];
          REG_LOW_LIMIT:   shadow_regs.low_limit        = cfg_data_i[SAMPLE_BITS-1:0];
          REG_HIGH_LIMIT:  shadow_regs.high_limit       = cfg_data_i[SAMPLE_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (conditioned_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("rcc check: result %0d arrived with nothing outstanding (value %0d)",
                     results_seen, out_data_i.channel_value);
          fail_count_o++;
        end else begin
          want = conditioned_q.pop_front();
          if (out_data_i.channel_value    !== want.channel_value    ||
              out_data_i.failure_mask_out !== want.failure_mask_out ||
              out_data_i.switch_position  !== want.switch_position  ||
              out_data_i.normalized_value !== want.normalized_value ||
              out_data_i.normalize_error  !== want.normalize_error) begin
            if (fail_count_o < MAX_REPORTS) begin
              $display("rcc check: result %0d mismatch (expected / actual)", results_seen);
              $display("  value %0d / %0d  mask %h / %h  switch %0d / %0d",
                       want.channel_value, out_data_i.channel_value,
                       want.failure_mask_out, out_data_i.failure_mask_out,
                       want.switch_position, out_data_i.switch_position);
              $display("  norm %0d / %0d  norm_err %0d / %0d",
                       want.normalized_value, out_data_i.normalized_value,
                       want.normalize_error, out_data_i.normalize_error);
            end
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        want       = condition_pulse(shadow_regs, kept_width, in_data_i);
        kept_width = want.channel_value;
        conditioned_q.push_back(want);
      end
      outstanding_o = conditioned_q.size();
    end
  end

endmodule

// ----- tb/rc_channel_conditioner_test.sv -----
// Testbench top for the RC channel conditioner: clock, reset, stimulus and verdict.
module rc_channel_conditioner_test;
  import rcc_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 175;
  localparam int DRAIN_CYCLES  = 40;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_ZERO_POINT;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  int unsigned              fail_count;
  int unsigned              outstanding;
  int unsigned              stuck_cycles = 0;
  bit                       quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc_channel_conditioner DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rcc_result_checker result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STALL_LIMIT);
    $display("[rc_channel_conditioner] ERROR");
    $finish;
  end

  // Result back-pressure: random stall bursts with idle-free runs between, none in quiet mode
  initial begin
    wait (rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 13)) @(negedge clk) out_stall <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 12))
        @(negedge clk) out_stall <= 1'b0;
    end
  end

  // One input transfer, with an occasional gap first; returns at a falling edge
  task automatic send_item(input logic [SAMPLE_BITS-1:0] width,
                           input logic [MASK_BITS-1:0] mask);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_data.pulse_width     <= width;
    in_data.failure_mask_in <= mask;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold input until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write the full register set once the block is idle
  task automatic program_config(input cfg_t c);
    settle();
    write_reg(REG_ZERO_POINT,  c.zero_point);
    write_reg(REG_FULL_SCALE,  c.full_scale_point);
    write_reg(REG_FILTER_EN,   {11'b0, c.filter_enable});
    write_reg(REG_FILTER_GAIN, {3'b0, c.filter_gain});
    write_reg(REG_CHANNEL_IDX, {7'b0, c.channel_index});
    write_reg(REG_LOW_LIMIT,   c.low_limit);
    write_reg(REG_HIGH_LIMIT,  c.high_limit);
    cfg_valid <= 1'b0;
  endtask

  // Mostly sensible spans and limits, with a share of arbitrary ones
  function automatic cfg_t random_setup();
    cfg_t c;
    c.zero_point       = SAMPLE_BITS'($urandom_range(1000, 1700));
    c.full_scale_point = SAMPLE_BITS'(c.zero_point + $urandom_range(50, 900));
    if ($urandom_range(0, 4) == 0) begin
      c.zero_point       = SAMPLE_BITS'($urandom_range(0, 4095));
      c.full_scale_point = SAMPLE_BITS'($urandom_range(0, 4095));
    end
    c.filter_enable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       c.filter_gain = GAIN_BITS'($urandom_range(0, 511));
      1:       c.filter_gain = GAIN_ONE;
      default: c.filter_gain = GAIN_BITS'($urandom_range(8, 250));
    endcase
    c.channel_index = ($urandom_range(0, 5) == 0) ? CHAN_BITS'($urandom_range(0, 31))
                                                   : CHAN_BITS'($urandom_range(1, 16));
    c.low_limit  = SAMPLE_BITS'($urandom_range(600, 1200));
    c.high_limit = SAMPLE_BITS'($urandom_range(1800, 2400));
    if ($urandom_range(0, 5) == 0) begin
      c.low_limit  = SAMPLE_BITS'($urandom_range(0, 4095));
      c.high_limit = SAMPLE_BITS'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  initial begin
    cfg_t                   cur;
    logic [SAMPLE_BITS-1:0] width;
    logic [MASK_BITS-1:0]   mask;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // field order: zero, full scale, filter on, gain, channel, low, high
    // smoothing on straight from reset, against the failsafe width
    program_config('{12'd1500, 12'd2000, 1'b1, 9'd128, 5'd1, 12'd800, 12'd2200});
    send_item(12'd0, 16'h0000);
    send_item(12'd4095, 16'hFFFF);
    send_item(12'd2048, 16'h5555);

    // raw samples: switch edges, limit edges, saturation both ways, top channel
    program_config('{12'd1500, 12'd2000, 1'b0, 9'd128, 5'd16, 12'd800, 12'd2200});
    send_item(12'd0, 16'hAAAA);
    send_item(12'd4095, 16'h0000);
    send_item(12'd1249, 16'hFFFF);
    send_item(12'd1250, 16'h0001);
    send_item(12'd1749, 16'h8000);
    send_item(12'd1750, 16'h7FFF);
    send_item(12'd799, 16'h0000);
    send_item(12'd800, 16'h0000);
    send_item(12'd2200, 16'h0000);
    send_item(12'd2201, 16'h5555);
    send_item(12'd1500, 16'h0000);
    send_item(12'd2000, 16'h0000);

    // zero span, crossed limits, no channel bit, gain beyond unity
    program_config('{12'd2000, 12'd2000, 1'b1, 9'd300, 5'd0, 12'd3000, 12'd100});
    send_item(12'd1000, 16'h1234);
    send_item(12'd3000, 16'h0000);

    // negative span, channel past the mask, zero gain holds the kept value
    program_config('{12'd4095, 12'd0, 1'b1, 9'd0, 5'd17, 12'd800, 12'd2200});
    send_item(12'd123, 16'h0000);

    // widest span, unity gain, channel 31, widest limits
    program_config('{12'd0, 12'd4095, 1'b1, 9'd256, 5'd31, 12'd0, 12'd4095});
    send_item(12'd0, 16'hFFFF);
    send_item(12'd4095, 16'h0000);

    // one-count span saturates, smallest nonzero gain
    program_config('{12'd1500, 12'd1501, 1'b1, 9'd1, 5'd1, 12'd800, 12'd2200});
    send_item(12'd4095, 16'h0000);
    send_item(12'd0, 16'hFFFE);

    // Random phases, each under a fresh register set; the last one runs without idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      cur = random_setup();
      program_config(cur);
      if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: width = SAMPLE_BITS'($urandom_range(0, 4095));
          1: begin
            case ($urandom_range(0, 5))
              0:       width = '0;
              1:       width = '1;
              2:       width = SAMPLE_BITS'(SWITCH_LOW_EDGE - 1 + $urandom_range(0, 1));
              3:       width = SAMPLE_BITS'(SWITCH_HIGH_EDGE - 1 + $urandom_range(0, 1));
              4:       width = SAMPLE_BITS'(cur.low_limit - 1 + $urandom_range(0, 1));
              default: width = SAMPLE_BITS'(cur.high_limit + $urandom_range(0, 1));
            endcase
          end
          default: width = SAMPLE_BITS'($urandom_range(700, 2400));
        endcase
        case ($urandom_range(0, 7))
          0:       mask = '0;
          1:       mask = '1;
          default: mask = MASK_BITS'($urandom_range(0, 65535));
        endcase
        send_item(width, mask);
        // sender holds off until the pipeline has emptied
        if ((phase == 3 && n == PHASE_ITEMS / 2) || (!quiet && $urandom_range(0, 149) == 0))
          settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[rc_channel_conditioner] OK");
    else
      $display("[rc_channel_conditioner] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/rcc_pkg.sv
src/rcc_cfg_regs.sv
src/rcc_ctrl.sv
src/rcc_datapath.sv
src/rc_channel_conditioner.sv
src/rcc_checker.sv
tb/rcc_result_checker.sv
tb/rc_channel_conditioner_test.sv
